FILE: hw/rtl/ufrd_pkg.sv
// Package for the UART FIFO register device: sizes, codes, state type and
// the command/status structs between controller and datapath. No dependencies.
package ufrd_pkg;

	localparam int FIFO_DEPTH   = 16;
	localparam int PTR_W        = $clog2(FIFO_DEPTH);
	localparam int FILL_W       = $clog2(FIFO_DEPTH + 1);
	localparam int DATA_W       = 64;
	localparam int IRQ_LINES    = 32;
	localparam int IRQ_W        = 5;
	localparam logic [DATA_W-1:0] DEFAULT_BAUD = DATA_W'(115200);

	localparam logic [2:0] KIND_READ  = 3'd0;
	localparam logic [2:0] KIND_WRITE = 3'd1;
	localparam logic [2:0] KIND_RECV  = 3'd2;
	localparam logic [2:0] KIND_TICK  = 3'd3;
	localparam logic [2:0] KIND_SRST  = 3'd4;

	localparam logic [2:0] SEL_RXDATA  = 3'd0;
	localparam logic [2:0] SEL_TXDATA  = 3'd1;
	localparam logic [2:0] SEL_STATUS  = 3'd2;
	localparam logic [2:0] SEL_CONTROL = 3'd3;
	localparam logic [2:0] SEL_BAUD    = 3'd4;
	localparam logic [2:0] SEL_IRQ     = 3'd5;

	localparam logic [3:0] BYTES_DATA = 4'd1;
	localparam logic [3:0] BYTES_REG  = 4'd8;

	localparam logic [1:0] RK_ACCESS = 2'd0;
	localparam logic [1:0] RK_TX     = 2'd1;
	localparam logic [1:0] RK_TICK   = 2'd2;

	localparam int CTL_EN   = 0;
	localparam int CTL_RXIE = 1;
	localparam int CTL_TXIE = 2;
	localparam int ERR_RX   = 0;
	localparam int ERR_TX   = 1;
	localparam int PND_RX   = 0;
	localparam int PND_TX   = 1;

	localparam logic [7:0] CFG_IRQ_LINE = 8'd0;
	localparam logic [7:0] CFG_TX_SINK  = 8'd1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TX_POP,
		S_TICK_END,
		S_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic tx_pop;
		logic tick_end;
	} cmd_t;

	typedef struct packed {
		logic drain_go;
		logic tick_go;
		logic last;
		logic tx_more;
	} sts_t;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

FILE: hw/rtl/ufrd_ctrl.sv
// Controller state machine for the UART FIFO register device.
// Depends on ufrd_pkg; drives commands to ufrd_dp and reads its status.
module ufrd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  ufrd_pkg::sts_t  sts,
	output ufrd_pkg::cmd_t  cmd
);

	ufrd_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ufrd_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ufrd_pkg::S_IDLE: begin
				if (in_valid) state_d = ufrd_pkg::S_EXEC;
			end
			ufrd_pkg::S_EXEC: begin
				if (sts.drain_go) state_d = ufrd_pkg::S_TX_POP;
				else if (sts.tick_go) state_d = ufrd_pkg::S_TICK_END;
				else state_d = ufrd_pkg::S_OUT;
			end
			ufrd_pkg::S_TX_POP: state_d = ufrd_pkg::S_OUT;
			ufrd_pkg::S_TICK_END: state_d = ufrd_pkg::S_OUT;
			ufrd_pkg::S_OUT: begin
				if (!out_stall) begin
					if (sts.last) state_d = ufrd_pkg::S_IDLE;
					else if (sts.tx_more) state_d = ufrd_pkg::S_TX_POP;
					else state_d = ufrd_pkg::S_TICK_END;
				end
			end
			default: state_d = ufrd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall     = (state_q != ufrd_pkg::S_IDLE);
		out_valid    = (state_q == ufrd_pkg::S_OUT);
		cmd.capture  = (state_q == ufrd_pkg::S_IDLE) && in_valid;
		cmd.exec     = (state_q == ufrd_pkg::S_EXEC) && !sts.drain_go && !sts.tick_go;
		cmd.tx_pop   = (state_q == ufrd_pkg::S_TX_POP);
		cmd.tick_end = (state_q == ufrd_pkg::S_TICK_END);
	end

	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tx_pop |=> out_valid)
		else $error("transmit pop not followed by a result");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open while a result is pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("stalled result dropped");

endmodule

FILE: hw/rtl/ufrd_dp.sv
// Datapath of the UART FIFO register device: item capture, RX/TX byte FIFOs,
// control/status registers and the result register. Depends on ufrd_pkg.
module ufrd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ufrd_pkg::cmd_t                cmd,
	output ufrd_pkg::sts_t                sts,
	input  logic [2:0]                    kind,
	input  logic [2:0]                    reg_select,
	input  logic [3:0]                    access_bytes,
	input  logic [ufrd_pkg::DATA_W-1:0]   data_in,
	input  logic [7:0]                    tick_count,
	input  logic                          cfg_we,
	input  logic [7:0]                    cfg_index,
	input  logic [ufrd_pkg::DATA_W-1:0]   cfg_data,
	output logic [1:0]                    result_kind,
	output logic                          ok,
	output logic [ufrd_pkg::DATA_W-1:0]   read_data,
	output logic [7:0]                    tx_data,
	output logic                          irq_raise,
	output logic [ufrd_pkg::IRQ_W-1:0]    irq_number,
	output logic                          last
);

	logic [2:0]                  kind_q, sel_q;
	logic [3:0]                  bytes_q;
	logic [ufrd_pkg::DATA_W-1:0] data_q;
	logic [7:0]                  ticks_q;

	logic [7:0] rx_mem [ufrd_pkg::FIFO_DEPTH];
	logic [7:0] tx_mem [ufrd_pkg::FIFO_DEPTH];
	logic [7:0] rx_rdata_q, tx_rdata_q;
	logic       rx_push, tx_push;

	logic [ufrd_pkg::PTR_W-1:0]  rx_rd_q, rx_wr_q, tx_rd_q, tx_wr_q;
	logic [ufrd_pkg::PTR_W-1:0]  rx_rd_d, rx_wr_d, tx_rd_d, tx_wr_d;
	logic [ufrd_pkg::FILL_W-1:0] rx_fill_q, tx_fill_q, rx_fill_d, tx_fill_d;
	logic [2:0]                  ctrl_q, ctrl_d;
	logic [ufrd_pkg::DATA_W-1:0] baud_q, baud_d;
	logic [1:0]                  err_q, err_d, pend_q, pend_d, pend_tick;

	logic [ufrd_pkg::IRQ_W-1:0]  irq_line_q;
	logic                        sink_q;

	logic [1:0]                  res_kind_q, res_kind_d;
	logic                        res_ok_q, res_ok_d;
	logic [ufrd_pkg::DATA_W-1:0] res_rdata_q, res_rdata_d;
	logic [7:0]                  res_tx_q, res_tx_d;
	logic                        res_raise_q, res_raise_d;
	logic [ufrd_pkg::IRQ_W-1:0]  res_irqn_q, res_irqn_d;
	logic                        res_last_q, res_last_d;

	logic                        en, rx_full, tx_full, raise;
	logic [ufrd_pkg::DATA_W-1:0] status_word;

	assign en      = ctrl_q[ufrd_pkg::CTL_EN];
	assign rx_full = (rx_fill_q >= ufrd_pkg::FILL_W'(ufrd_pkg::FIFO_DEPTH));
	assign tx_full = (tx_fill_q >= ufrd_pkg::FILL_W'(ufrd_pkg::FIFO_DEPTH));
	assign status_word = {{(ufrd_pkg::DATA_W - 5){1'b0}}, err_q, (tx_fill_q == '0),
		en && !tx_full, (rx_fill_q != '0)};
	assign pend_tick = {pend_q[ufrd_pkg::PND_TX],
		pend_q[ufrd_pkg::PND_RX] | (en && (rx_fill_q != '0))};
	assign raise = en && ((pend_tick & {ctrl_q[ufrd_pkg::CTL_TXIE],
		ctrl_q[ufrd_pkg::CTL_RXIE]}) != 2'b00);

	assign sts.drain_go = (kind_q == ufrd_pkg::KIND_TICK) && (ticks_q != '0) && en
		&& sink_q && (tx_fill_q != '0);
	assign sts.tick_go  = (kind_q == ufrd_pkg::KIND_TICK) && (ticks_q != '0)
		&& !sts.drain_go;
	assign sts.last     = res_last_q;
	assign sts.tx_more  = (tx_fill_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q  <= kind;
			sel_q   <= reg_select;
			bytes_q <= access_bytes;
			data_q  <= data_in;
			ticks_q <= tick_count;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_push) rx_mem[rx_wr_q] <= data_q[7:0];
		rx_rdata_q <= rx_mem[rx_rd_q];
	end

	always_ff @(posedge clk) begin
		if (tx_push) tx_mem[tx_wr_q] <= data_q[7:0];
		tx_rdata_q <= tx_mem[tx_rd_q];
	end

	always_comb begin
		rx_rd_d = rx_rd_q;   rx_wr_d = rx_wr_q;   rx_fill_d = rx_fill_q;
		tx_rd_d = tx_rd_q;   tx_wr_d = tx_wr_q;   tx_fill_d = tx_fill_q;
		ctrl_d = ctrl_q;     baud_d = baud_q;     err_d = err_q;   pend_d = pend_q;
		rx_push = 1'b0;      tx_push = 1'b0;
		res_kind_d = res_kind_q;   res_ok_d = res_ok_q;       res_rdata_d = res_rdata_q;
		res_tx_d = res_tx_q;       res_raise_d = res_raise_q; res_irqn_d = res_irqn_q;
		res_last_d = res_last_q;

		if (cmd.exec) begin
			res_kind_d  = ufrd_pkg::RK_ACCESS;
			res_ok_d    = 1'b0;
			res_rdata_d = '0;
			res_tx_d    = '0;
			res_raise_d = 1'b0;
			res_irqn_d  = '0;
			res_last_d  = 1'b1;
			case (kind_q)
				ufrd_pkg::KIND_READ: begin
					if (sel_q == ufrd_pkg::SEL_RXDATA && bytes_q == ufrd_pkg::BYTES_DATA) begin
						res_ok_d = 1'b1;
						if (rx_fill_q != '0) begin
							res_rdata_d = ufrd_pkg::DATA_W'(rx_rdata_q);
							rx_rd_d     = ufrd_pkg::ptr_next(rx_rd_q);
							rx_fill_d   = rx_fill_q - 1'b1;
							if (rx_fill_q == ufrd_pkg::FILL_W'(1)) pend_d[ufrd_pkg::PND_RX] = 1'b0;
						end
					end else if (bytes_q == ufrd_pkg::BYTES_REG) begin
						case (sel_q)
							ufrd_pkg::SEL_STATUS: begin
								res_ok_d = 1'b1;  res_rdata_d = status_word;
							end
							ufrd_pkg::SEL_CONTROL: begin
								res_ok_d = 1'b1;  res_rdata_d = ufrd_pkg::DATA_W'(ctrl_q);
							end
							ufrd_pkg::SEL_BAUD: begin
								res_ok_d = 1'b1;  res_rdata_d = baud_q;
							end
							ufrd_pkg::SEL_IRQ: begin
								res_ok_d = 1'b1;  res_rdata_d = ufrd_pkg::DATA_W'(pend_q);
							end
							default: ;
						endcase
					end
				end
				ufrd_pkg::KIND_WRITE: begin
					if (sel_q == ufrd_pkg::SEL_TXDATA && bytes_q == ufrd_pkg::BYTES_DATA) begin
						res_ok_d = 1'b1;
						if (en) begin
							if (tx_full) begin
								err_d[ufrd_pkg::ERR_TX] = 1'b1;
							end else begin
								tx_push   = 1'b1;
								tx_wr_d   = ufrd_pkg::ptr_next(tx_wr_q);
								tx_fill_d = tx_fill_q + 1'b1;
								pend_d[ufrd_pkg::PND_TX] = 1'b0;
							end
						end
					end else if (bytes_q == ufrd_pkg::BYTES_REG) begin
						case (sel_q)
							ufrd_pkg::SEL_STATUS: begin
								res_ok_d = 1'b1;  err_d = err_q & ~data_q[4:3];
							end
							ufrd_pkg::SEL_CONTROL: begin
								res_ok_d = 1'b1;  ctrl_d = data_q[2:0];
							end
							ufrd_pkg::SEL_BAUD: begin
								res_ok_d = 1'b1;  baud_d = data_q;
							end
							ufrd_pkg::SEL_IRQ: begin
								res_ok_d = 1'b1;  pend_d = pend_q & ~data_q[1:0];
							end
							default: ;
						endcase
					end
				end
				ufrd_pkg::KIND_RECV: begin
					if (en) begin
						pend_d[ufrd_pkg::PND_RX] = 1'b1;
						if (rx_full) begin
							err_d[ufrd_pkg::ERR_RX] = 1'b1;
						end else begin
							res_ok_d  = 1'b1;
							rx_push   = 1'b1;
							rx_wr_d   = ufrd_pkg::ptr_next(rx_wr_q);
							rx_fill_d = rx_fill_q + 1'b1;
						end
					end
				end
				ufrd_pkg::KIND_TICK: res_kind_d = ufrd_pkg::RK_TICK;
				ufrd_pkg::KIND_SRST: begin
					res_ok_d = 1'b1;
					rx_rd_d = '0;  rx_wr_d = '0;  rx_fill_d = '0;
					tx_rd_d = '0;  tx_wr_d = '0;  tx_fill_d = '0;
					ctrl_d = '0;   baud_d = ufrd_pkg::DEFAULT_BAUD;
					err_d = '0;    pend_d = '0;
				end
				default: ;
			endcase
		end

		if (cmd.tx_pop) begin
			res_kind_d  = ufrd_pkg::RK_TX;
			res_ok_d    = 1'b0;
			res_rdata_d = '0;
			res_tx_d    = tx_rdata_q;
			res_raise_d = 1'b0;
			res_irqn_d  = '0;
			res_last_d  = 1'b0;
			tx_rd_d     = ufrd_pkg::ptr_next(tx_rd_q);
			tx_fill_d   = tx_fill_q - 1'b1;
			if (tx_fill_q == ufrd_pkg::FILL_W'(1)) pend_d[ufrd_pkg::PND_TX] = 1'b1;
		end

		if (cmd.tick_end) begin
			pend_d      = pend_tick;
			res_kind_d  = ufrd_pkg::RK_TICK;
			res_ok_d    = 1'b0;
			res_rdata_d = '0;
			res_tx_d    = '0;
			res_raise_d = raise;
			res_irqn_d  = raise ? irq_line_q : '0;
			res_last_d  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_rd_q <= '0;  rx_wr_q <= '0;  rx_fill_q <= '0;
			tx_rd_q <= '0;  tx_wr_q <= '0;  tx_fill_q <= '0;
			ctrl_q <= '0;   baud_q <= ufrd_pkg::DEFAULT_BAUD;
			err_q <= '0;    pend_q <= '0;
		end else begin
			rx_rd_q <= rx_rd_d;  rx_wr_q <= rx_wr_d;  rx_fill_q <= rx_fill_d;
			tx_rd_q <= tx_rd_d;  tx_wr_q <= tx_wr_d;  tx_fill_q <= tx_fill_d;
			ctrl_q <= ctrl_d;    baud_q <= baud_d;
			err_q <= err_d;      pend_q <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		res_kind_q  <= res_kind_d;
		res_ok_q    <= res_ok_d;
		res_rdata_q <= res_rdata_d;
		res_tx_q    <= res_tx_d;
		res_raise_q <= res_raise_d;
		res_irqn_q  <= res_irqn_d;
		res_last_q  <= res_last_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_line_q <= '0;
			sink_q     <= 1'b1;
		end else if (cfg_we) begin
			if (cfg_index == ufrd_pkg::CFG_IRQ_LINE) begin
				if ({1'b0, cfg_data[ufrd_pkg::IRQ_W-1:0]} < (ufrd_pkg::IRQ_W + 1)'(ufrd_pkg::IRQ_LINES))
					irq_line_q <= cfg_data[ufrd_pkg::IRQ_W-1:0];
			end else if (cfg_index == ufrd_pkg::CFG_TX_SINK) begin
				sink_q <= cfg_data[0];
			end
		end
	end

	assign result_kind = res_kind_q;
	assign ok          = res_ok_q;
	assign read_data   = res_rdata_q;
	assign tx_data     = res_tx_q;
	assign irq_raise   = res_raise_q;
	assign irq_number  = res_irqn_q;
	assign last        = res_last_q;

	a_rx_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q <= ufrd_pkg::FILL_W'(ufrd_pkg::FIFO_DEPTH))
		else $error("rx fill beyond depth");

	a_tx_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		tx_fill_q <= ufrd_pkg::FILL_W'(ufrd_pkg::FIFO_DEPTH))
		else $error("tx fill beyond depth");

	a_rx_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		((rx_fill_q == '0) || rx_full) == (rx_wr_q == rx_rd_q))
		else $error("rx pointers disagree with fill");

	a_tx_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		((tx_fill_q == '0) || tx_full) == (tx_wr_q == tx_rd_q))
		else $error("tx pointers disagree with fill");

endmodule

FILE: hw/rtl/uart_fifo_register_device.sv
// UART FIFO register device: top level joining ufrd_ctrl and ufrd_dp.
// Depends on ufrd_pkg, ufrd_ctrl and ufrd_dp.
//
// Input channel (in_valid/in_stall) carries one item per transaction: a bus
// read or write, a byte received from the line, a tick or a soft reset. The
// output channel (out_valid/out_stall) returns result rows; last marks the
// final row of an item. A side channel (cfg_valid/cfg_ready) writes irq_line
// (index 0) and tx_sink_attached (index 1); it is always ready.
// One item is in flight at a time: in_stall is high from acceptance until
// the item's last result transaction completes.
// The first result follows acceptance through the execute state; a tick with
// a nonzero count passes through a pop or tick-end state before it.
// A tick that drains bytes from the transmit FIFO takes, for each byte, a
// pop state through the registered FIFO read port and an output state, then
// a tick-end state and its output.
// A stall on the output holds the current result and the whole block.
// Reset empties both FIFOs, clears control, error and pending bits, loads
// the default baud value and sets irq_line to 0 and tx_sink_attached to 1.
// Soft reset does the same but keeps irq_line and tx_sink_attached.
module uart_fifo_register_device (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    kind,
	input  logic [2:0]                    reg_select,
	input  logic [3:0]                    access_bytes,
	input  logic [ufrd_pkg::DATA_W-1:0]   data_in,
	input  logic [7:0]                    tick_count,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    result_kind,
	output logic                          ok,
	output logic [ufrd_pkg::DATA_W-1:0]   read_data,
	output logic [7:0]                    tx_data,
	output logic                          irq_raise,
	output logic [ufrd_pkg::IRQ_W-1:0]    irq_number,
	output logic                          last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [7:0]                    cfg_index,
	input  logic [ufrd_pkg::DATA_W-1:0]   cfg_data
);

	ufrd_pkg::cmd_t cmd;
	ufrd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	ufrd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ufrd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.kind         (kind),
		.reg_select   (reg_select),
		.access_bytes (access_bytes),
		.data_in      (data_in),
		.tick_count   (tick_count),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_kind  (result_kind),
		.ok           (ok),
		.read_data    (read_data),
		.tx_data      (tx_data),
		.irq_raise    (irq_raise),
		.irq_number   (irq_number),
		.last         (last)
	);

endmodule

FILE: tb/sv/testbench.sv
// Testbench for uart_fifo_register_device: drives bus, line, tick and soft-reset
// transactions, predicts every result row with a shadow register model in a
// scoreboard class, and checks rows in order. Depends on ufrd_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
	import ufrd_pkg::*;

	localparam logic [2:0] KIND_RSVD    = 3'd7;
	localparam logic [2:0] SEL_UNMAPPED = 3'd7;
	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 17;
	localparam int BURST_ITEMS = 18;

	typedef struct {
		logic [2:0]  kind;
		logic [2:0]  sel;
		logic [3:0]  nbytes;
		logic [63:0] data;
		logic [7:0]  ticks;
	} uart_item_t;

	typedef struct {
		logic [1:0]  rkind;
		logic        ok;
		logic [63:0] rdata;
		logic [7:0]  txd;
		logic        raise;
		logic [4:0]  irq_num;
		logic        last;
	} uart_row_t;

	class uart_reg_scoreboard;
		logic [7:0]  rx_bytes [FIFO_DEPTH];
		logic [7:0]  tx_bytes [FIFO_DEPTH];
		int          rx_head, rx_tail, rx_level;
		int          tx_head, tx_tail, tx_level;
		logic [2:0]  control;
		logic [63:0] baud;
		logic [1:0]  err_flags;
		logic [1:0]  pending;
		logic [4:0]  irq_line;
		logic        tx_sink;
		uart_row_t   expected_rows[$];
		int          mismatches, items_seen, rows_seen, tx_sent, raises;

		function new();
			clear_regs();
			irq_line = '0;
			tx_sink = 1'b1;
		endfunction

		function void clear_regs();
			rx_head = 0; rx_tail = 0; rx_level = 0;
			tx_head = 0; tx_tail = 0; tx_level = 0;
			control = '0;
			baud = DEFAULT_BAUD;
			err_flags = '0;
			pending = '0;
		endfunction

		function void configure(logic [7:0] idx, logic [63:0] value);
			if (idx == CFG_IRQ_LINE)
				irq_line = value[4:0];
			else if (idx == CFG_TX_SINK)
				tx_sink = value[0];
		endfunction

		function void push_row(logic [1:0] rk, logic okv, logic [63:0] rd, logic [7:0] b,
				logic raise, logic [4:0] num, logic fin);
			uart_row_t r;
			r = '{rkind: rk, ok: okv, rdata: rd, txd: b, raise: raise, irq_num: num, last: fin};
			expected_rows.push_back(r);
		endfunction

		function int outstanding();
			return expected_rows.size();
		endfunction

		function void note_item(uart_item_t it);
			logic [63:0] rd;
			logic        okv;
			logic [1:0]  mask;
			logic [7:0]  b;
			logic        en, raise;
			items_seen++;
			en = control[CTL_EN];
			rd = '0;
			okv = 1'b1;
			case (it.kind)
				KIND_READ: begin
					if (it.sel == SEL_RXDATA && it.nbytes == BYTES_DATA) begin
						if (rx_level != 0) begin
							rd = 64'(rx_bytes[rx_head]);
							rx_head = (rx_head + 1) % FIFO_DEPTH;
							rx_level--;
							if (rx_level == 0)
								pending[PND_RX] = 1'b0;
						end
					end else if (it.nbytes != BYTES_REG) begin
						okv = 1'b0;
					end else begin
						case (it.sel)
							SEL_STATUS: rd = {59'd0, err_flags, tx_level == 0,
								en && tx_level < FIFO_DEPTH, rx_level != 0};
							SEL_CONTROL: rd = 64'(control);
							SEL_BAUD: rd = baud;
							SEL_IRQ: rd = 64'(pending);
							default: okv = 1'b0;
						endcase
					end
					push_row(RK_ACCESS, okv, okv ? rd : 64'd0, '0, 1'b0, '0, 1'b1);
				end
				KIND_WRITE: begin
					if (it.sel == SEL_TXDATA && it.nbytes == BYTES_DATA) begin
						if (en) begin
							if (tx_level >= FIFO_DEPTH) begin
								err_flags[ERR_TX] = 1'b1;
							end else begin
								tx_bytes[tx_tail] = it.data[7:0];
								tx_tail = (tx_tail + 1) % FIFO_DEPTH;
								tx_level++;
								pending[PND_TX] = 1'b0;
							end
						end
					end else if (it.nbytes != BYTES_REG) begin
						okv = 1'b0;
					end else begin
						case (it.sel)
							SEL_STATUS: err_flags &= ~it.data[4:3];
							SEL_CONTROL: control = it.data[2:0];
							SEL_BAUD: baud = it.data;
							SEL_IRQ: pending &= ~it.data[1:0];
							default: okv = 1'b0;
						endcase
					end
					push_row(RK_ACCESS, okv, '0, '0, 1'b0, '0, 1'b1);
				end
				KIND_RECV: begin
					okv = 1'b0;
					if (en) begin
						pending[PND_RX] = 1'b1;
						if (rx_level >= FIFO_DEPTH) begin
							err_flags[ERR_RX] = 1'b1;
						end else begin
							rx_bytes[rx_tail] = it.data[7:0];
							rx_tail = (rx_tail + 1) % FIFO_DEPTH;
							rx_level++;
							okv = 1'b1;
						end
					end
					push_row(RK_ACCESS, okv, '0, '0, 1'b0, '0, 1'b1);
				end
				KIND_TICK: begin
					if (it.ticks == 0) begin
						push_row(RK_TICK, 1'b0, '0, '0, 1'b0, '0, 1'b1);
					end else begin
						if (en && tx_sink) begin
							while (tx_level != 0) begin
								b = tx_bytes[tx_head];
								tx_head = (tx_head + 1) % FIFO_DEPTH;
								tx_level--;
								if (tx_level == 0)
									pending[PND_TX] = 1'b1;
								push_row(RK_TX, 1'b0, '0, b, 1'b0, '0, 1'b0);
							end
						end
						if (en && rx_level != 0)
							pending[PND_RX] = 1'b1;
						mask[PND_RX] = control[CTL_RXIE];
						mask[PND_TX] = control[CTL_TXIE];
						raise = en && ((pending & mask) != 0);
						push_row(RK_TICK, 1'b0, '0, '0, raise, raise ? irq_line : 5'd0, 1'b1);
					end
				end
				KIND_SRST: begin
					clear_regs();
					push_row(RK_ACCESS, 1'b1, '0, '0, 1'b0, '0, 1'b1);
				end
				default: push_row(RK_ACCESS, 1'b0, '0, '0, 1'b0, '0, 1'b1);
			endcase
		endfunction

		task report(string what);
			mismatches++;
			$display("[%0t] MISMATCH %s", $realtime, what);
		endtask

		task compare(string field, logic [63:0] got, logic [63:0] want);
			if (got !== want)
				report($sformatf("row %0d %s: got %0h, expected %0h", rows_seen, field, got, want));
		endtask

		task check_row(uart_row_t got);
			uart_row_t want;
			rows_seen++;
			if (got.rkind === RK_TX)
				tx_sent++;
			if (got.raise === 1'b1)
				raises++;
			if (expected_rows.size() == 0) begin
				report($sformatf("row %0d arrived with nothing expected", rows_seen));
				return;
			end
			want = expected_rows.pop_front();
			compare("result_kind", 64'(got.rkind), 64'(want.rkind));
			compare("ok", 64'(got.ok), 64'(want.ok));
			compare("read_data", got.rdata, want.rdata);
			compare("tx_data", 64'(got.txd), 64'(want.txd));
			compare("irq_raise", 64'(got.raise), 64'(want.raise));
			compare("irq_number", 64'(got.irq_num), 64'(want.irq_num));
			compare("last", 64'(got.last), 64'(want.last));
		endtask

		task flush_leftovers();
			while (expected_rows.size() != 0) begin
				void'(expected_rows.pop_front());
				report("expected row never arrived");
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  kind;
	logic [2:0]  reg_select;
	logic [3:0]  access_bytes;
	logic [63:0] data_in;
	logic [7:0]  tick_count;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic        ok;
	logic [63:0] read_data;
	logic [7:0]  tx_data;
	logic        irq_raise;
	logic [4:0]  irq_number;
	logic        last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [63:0] cfg_data;

	uart_reg_scoreboard sb = new();
	int  send_idle_pct;
	int  stall_pct;
	bit  hold_off;
	int  quiet_cycles;

	uart_fifo_register_device i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.reg_select   (reg_select),
		.access_bytes (access_bytes),
		.data_in      (data_in),
		.tick_count   (tick_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_kind  (result_kind),
		.ok           (ok),
		.read_data    (read_data),
		.tx_data      (tx_data),
		.irq_raise    (irq_raise),
		.irq_number   (irq_number),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic uart_item_t mk_item(logic [2:0] k, logic [2:0] s, logic [3:0] n,
			logic [63:0] d, logic [7:0] t);
		uart_item_t it;
		it = '{kind: k, sel: s, nbytes: n, data: d, ticks: t};
		return it;
	endfunction

	function automatic uart_item_t gen_item();
		uart_item_t it;
		int pick;
		it = mk_item(KIND_WRITE, SEL_TXDATA, BYTES_DATA, {$urandom, $urandom},
			8'($urandom_range(0, 255)));
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			it.kind = KIND_WRITE;
		end else if (pick < 48) begin
			it.kind = KIND_RECV;
		end else if (pick < 62) begin
			it.kind = KIND_READ;
			it.sel = SEL_RXDATA;
		end else if (pick < 70) begin
			it.sel = SEL_CONTROL;
			it.nbytes = BYTES_REG;
			it.data[CTL_EN] = ($urandom_range(0, 9) != 0);
		end else if (pick < 80) begin
			it.kind = $urandom_range(0, 1) ? KIND_READ : KIND_WRITE;
			it.sel = 3'($urandom_range(SEL_STATUS, SEL_IRQ));
			it.nbytes = BYTES_REG;
		end else if (pick < 90) begin
			it.kind = KIND_TICK;
			if ($urandom_range(0, 7) == 0)
				it.ticks = '0;
		end else if (pick < 92) begin
			it.kind = KIND_SRST;
		end else begin
			it.kind = 3'($urandom_range(0, 7));
			it.sel = 3'($urandom_range(0, 7));
			it.nbytes = 4'($urandom_range(0, 15));
		end
		return it;
	endfunction

	task automatic send_item(uart_item_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		kind = it.kind;
		reg_select = it.sel;
		access_bytes = it.nbytes;
		data_in = it.data;
		tick_count = it.ticks;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_item(it);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(logic [7:0] idx, logic [63:0] value);
		@(negedge clk);
		cfg_index = idx;
		cfg_data = value;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		sb.configure(idx, value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// receiver: stall at negedge, take the row at posedge
	initial begin
		uart_row_t row;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				row = '{rkind: result_kind, ok: ok, rdata: read_data, txd: tx_data,
					raise: irq_raise, irq_num: irq_number, last: last};
				sb.check_row(row);
			end
			@(negedge clk);
			out_stall = hold_off || ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0) ||
					(cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
		$display("uart_fifo_register_device verification failed");
		$finish;
	end

	initial begin
		logic [63:0] value;
		int idle_by_phase [4];
		int stall_by_phase [4];
		idle_by_phase = '{0, 79, 0, 23};
		stall_by_phase = '{0, 0, 79, 23};
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		reg_select = '0;
		access_bytes = '0;
		data_in = '0;
		tick_count = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		cfg_write(CFG_IRQ_LINE, 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(mk_item(KIND_READ, SEL_STATUS, BYTES_REG, '0, '0));
		send_item(mk_item(KIND_READ, SEL_RXDATA, BYTES_DATA, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_TXDATA, BYTES_DATA, 64'h5A, '0));
		send_item(mk_item(KIND_RECV, SEL_RXDATA, BYTES_DATA, 64'h3C, '0));
		send_item(mk_item(KIND_READ, SEL_BAUD, BYTES_REG, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_CONTROL, BYTES_REG, '1, '0));
		send_item(mk_item(KIND_WRITE, SEL_BAUD, BYTES_REG, '1, '0));
		send_item(mk_item(KIND_READ, SEL_BAUD, BYTES_REG, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_STATUS, 4'd4, '1, '0));
		send_item(mk_item(KIND_READ, SEL_TXDATA, BYTES_DATA, '0, '0));
		send_item(mk_item(KIND_READ, SEL_UNMAPPED, BYTES_REG, '0, '0));
		send_item(mk_item(KIND_READ, SEL_CONTROL, 4'd0, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_CONTROL, 4'd15, '0, '0));
		send_item(mk_item(KIND_RECV, SEL_RXDATA, BYTES_DATA, '1, '0));
		send_item(mk_item(KIND_RECV, SEL_RXDATA, BYTES_DATA, 64'hFFFF_FFFF_FFFF_FF00, '0));
		send_item(mk_item(KIND_TICK, SEL_RXDATA, BYTES_DATA, '0, 8'd0));
		send_item(mk_item(KIND_WRITE, SEL_TXDATA, BYTES_DATA, '1, '0));
		send_item(mk_item(KIND_WRITE, SEL_TXDATA, BYTES_DATA, '0, '0));
		send_item(mk_item(KIND_TICK, SEL_RXDATA, BYTES_DATA, '0, 8'hFF));
		send_item(mk_item(KIND_READ, SEL_IRQ, BYTES_REG, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_IRQ, BYTES_REG, '1, '0));
		repeat (3) send_item(mk_item(KIND_READ, SEL_RXDATA, BYTES_DATA, '0, '0));
		send_item(mk_item(KIND_WRITE, SEL_STATUS, BYTES_REG, '1, '0));
		send_item(mk_item(KIND_RSVD, SEL_UNMAPPED, 4'd15, '1, 8'hFF));
		send_item(mk_item(KIND_SRST, SEL_RXDATA, BYTES_DATA, '0, '0));
		send_item(mk_item(KIND_READ, SEL_CONTROL, BYTES_REG, '0, '0));

		for (int ph = 0; ph < 4; ph++) begin
			wait_drain();
			send_idle_pct = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			value = {$urandom, $urandom};
			value[4:0] = (ph == 1) ? 5'd0 : (ph == 2) ? 5'($urandom_range(1, 30)) : 5'd31;
			cfg_write(CFG_IRQ_LINE, value);
			value = {$urandom, $urandom};
			value[0] = (ph % 2 == 0);
			cfg_write(CFG_TX_SINK, value);
			cfg_write(8'($urandom_range(2, 255)), {$urandom, $urandom});
			if (ph == 0) begin
				fork
					begin
						hold_off = 1'b1;
						repeat (HOLD_CYCLES) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			value = {$urandom, $urandom};
			value[CTL_EN] = 1'b1;
			send_item(mk_item(KIND_WRITE, SEL_CONTROL, BYTES_REG, value, '0));
			// fill past capacity: transmit side while nothing drains it, else receive side
			for (int i = 0; i < BURST_ITEMS; i++)
				send_item(mk_item((ph % 2 == 1) ? KIND_WRITE : KIND_RECV,
					(ph % 2 == 1) ? SEL_TXDATA : SEL_RXDATA, BYTES_DATA,
					{$urandom, $urandom}, '0));
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (ph == 2 && i == PHASE_ITEMS / 2)
					wait_drain();
				send_item(gen_item());
			end
		end

		wait_drain();
		repeat (20) @(posedge clk);
		sb.flush_leftovers();
		$display("covered %0d items, %0d result rows, %0d bytes transmitted, %0d irq raises",
			sb.items_seen, sb.rows_seen, sb.tx_sent, sb.raises);
		$display("idling: none, sender-only, receiver-only, both; one long receiver hold-off");
		if (sb.mismatches == 0)
			$display("uart_fifo_register_device verification clean");
		else
			$display("uart_fifo_register_device verification failed");
		$finish;
	end

endmodule
